### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions with asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CHM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/chm_pkg.sv
// ---------------------------------------------------------------------------
// chm_pkg
// Shared constants, types and helpers of the chained hash map engine.
// ---------------------------------------------------------------------------
`default_nettype none

package chm_pkg;

    // field widths
    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int KB_W  = 4;
    localparam int CNT_W = 7;

    // table geometry
    localparam int BUCKETS     = 10;
    localparam int CHAIN_DEPTH = 8;
    localparam int VALUE_BYTES = 8;
    localparam int SLOT_TOTAL  = BUCKETS * CHAIN_DEPTH;
    localparam int SLOT_AW     = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
    localparam int BKT_W       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CD_W        = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;

    // FNV-1a, 32 bit
    localparam logic [31:0] HASH_MULT = 32'h0100_0193;
    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;

    // shared multiplier geometry
    localparam int MUL_AW = 33;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // hash mod BUCKETS by reciprocal: q = (h * DIV_M) >> DIV_SH, exact for 32-bit h
    localparam int          DIV_L   = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
    localparam int          DIV_SH  = 32 + DIV_L;
    localparam logic [63:0] DIV_POW = 64'd1 << DIV_SH;
    localparam logic [MUL_AW-1:0] DIV_M =
        MUL_AW'((DIV_POW + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    // value mask from the stored value width
    localparam logic [VAL_W-1:0] VAL_MASK =
        (VALUE_BYTES >= 8) ? {VAL_W{1'b1}} : ((64'd1 << (8 * VALUE_BYTES)) - 64'd1);

    // configuration register
    localparam logic            REG_KEY_BYTES = 1'b0;
    localparam logic [KB_W-1:0] KEY_BYTES_RST = 4'd8;

    typedef enum logic
    {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_HASH,
        ST_DIVQ,
        ST_DIVR,
        ST_BASE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    // sequencer to slot store
    typedef struct packed
    {
        logic               rd_en;
        logic [SLOT_AW-1:0] rd_addr;
        logic               wr_val_en;
        logic               wr_key_en;
        logic [SLOT_AW-1:0] wr_addr;
        logic [KEY_W-1:0]   wr_key;
        logic [VAL_W-1:0]   wr_val;
    } store_req_t;

    // slot store to sequencer, registered read data
    typedef struct packed
    {
        logic [KEY_W-1:0] rd_key;
        logic [VAL_W-1:0] rd_val;
        logic             rd_valid;
    } store_rsp_t;

    typedef struct packed
    {
        logic             found;
        logic [VAL_W-1:0] value_out;
        logic             bucket_full;
        logic [CNT_W-1:0] entry_count;
    } result_t;

    // clamp the key length to 1..8 bytes
    function automatic logic [KB_W-1:0] eff_bytes(input logic [KB_W-1:0] kb);
        logic [KB_W-1:0] nb;
        nb = kb;
        if (kb == 4'd0)
        begin
            nb = 4'd1;
        end
        else if (kb > 4'd8)
        begin
            nb = 4'd8;
        end
        return nb;
    endfunction

    // mask covering the low nb bytes
    function automatic logic [KEY_W-1:0] byte_mask(input logic [KB_W-1:0] nb);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (KB_W'(i) < nb)
            begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/chm_in_if.sv
// ---------------------------------------------------------------------------
// chm_in_if
// Request channel: one get or set item per handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface chm_in_if;
    import chm_pkg::*;

    logic             valid;
    logic             ready;
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, output opcode, output key, output value, input ready);
    modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

`default_nettype wire

### hw/rtl/chm_out_if.sv
// ---------------------------------------------------------------------------
// chm_out_if
// Result channel: one result item per request item.
// ---------------------------------------------------------------------------
`default_nettype none

interface chm_out_if;
    import chm_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [VAL_W-1:0] value_out;
    logic             bucket_full;
    logic [CNT_W-1:0] entry_count;

    modport source (output valid, output found, output value_out, output bucket_full,
                    output entry_count, input ready);
    modport sink   (input valid, input found, input value_out, input bucket_full,
                    input entry_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/chm_mul.sv
// ---------------------------------------------------------------------------
// chm_mul
// Shared 33 x 32 multiplier used for hash rounds and the bucket modulo.
// ---------------------------------------------------------------------------
`default_nettype none

module chm_mul
(
    input  wire logic [chm_pkg::MUL_AW-1:0] a,
    input  wire logic [chm_pkg::MUL_BW-1:0] b,
    output logic      [chm_pkg::MUL_PW-1:0] p
);
    import chm_pkg::*;

    // full product, result is registered by the sequencer
    assign p = MUL_PW'(a) * MUL_PW'(b);

endmodule

`default_nettype wire

### hw/rtl/chm_store.sv
// ---------------------------------------------------------------------------
// chm_store
// Slot storage: key and value memories plus per-slot valid flags.
// ---------------------------------------------------------------------------
`default_nettype none

module chm_store
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire chm_pkg::store_req_t req,
    output chm_pkg::store_rsp_t      rsp
);
    import chm_pkg::*;

    logic [KEY_W-1:0]      key_mem [SLOT_TOTAL];
    logic [VAL_W-1:0]      val_mem [SLOT_TOTAL];
    logic [SLOT_TOTAL-1:0] valid_reg;

    logic [KEY_W-1:0] rd_key_reg;
    logic [VAL_W-1:0] rd_val_reg;
    logic             rd_valid_reg;

    // memory writes
    always_ff @(posedge clk)
    begin
        if (req.wr_key_en)
        begin
            key_mem[req.wr_addr] <= req.wr_key;
        end
        if (req.wr_val_en)
        begin
            val_mem[req.wr_addr] <= req.wr_val;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_key_reg   <= key_mem[req.rd_addr];
            rd_val_reg   <= val_mem[req.rd_addr];
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    // valid flags clear at reset, set on insert
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_key_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rsp.rd_key   = rd_key_reg;
    assign rsp.rd_val   = rd_val_reg;
    assign rsp.rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

### hw/rtl/chm_seq.sv
// ---------------------------------------------------------------------------
// chm_seq
// Sequencer: hash rounds, bucket modulo, slot walk and commit.
// ---------------------------------------------------------------------------
`default_nettype none

module chm_seq
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         opcode,
    input  wire logic [chm_pkg::KEY_W-1:0]    key,
    input  wire logic [chm_pkg::VAL_W-1:0]    value,
    input  wire logic [chm_pkg::KB_W-1:0]     key_bytes,
    input  wire logic                         out_free,
    output logic                              res_valid,
    output chm_pkg::result_t                  res,
    output chm_pkg::store_req_t               req,
    input  wire chm_pkg::store_rsp_t          rsp
);
    import chm_pkg::*;

    state_t state_reg, state_next;

    logic               op_reg,       op_next;
    logic [KB_W-1:0]    nb_reg,       nb_next;
    logic [KEY_W-1:0]   kmask_reg,    kmask_next;
    logic [KEY_W-1:0]   key_reg,      key_next;
    logic [KEY_W-1:0]   key_raw_reg,  key_raw_next;
    logic [VAL_W-1:0]   val_reg,      val_next;
    logic [2:0]         byte_idx_reg, byte_idx_next;
    logic [31:0]        h_reg,        h_next;
    logic [31:0]        q_reg,        q_next;
    logic [31:0]        qb_reg,       qb_next;
    logic [SLOT_AW-1:0] base_reg,     base_next;
    logic [CD_W-1:0]    slot_idx_reg, slot_idx_next;
    logic               eval_vld_reg, eval_vld_next;
    logic [CD_W-1:0]    eval_idx_reg, eval_idx_next;
    logic               hit_reg,      hit_next;
    logic [CD_W-1:0]    hit_idx_reg,  hit_idx_next;
    logic [VAL_W-1:0]   hit_val_reg,  hit_val_next;
    logic               free_reg,     free_next;
    logic [CD_W-1:0]    free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]   count_reg,    count_next;

    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic [MUL_PW-1:0] mul_p;
    logic [7:0]        hash_byte;
    logic [31:0]       rem;
    logic [KB_W-1:0]   in_nb;

    chm_mul u_mul
    (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    assign hash_byte = key_reg[{byte_idx_reg, 3'b000} +: 8];
    assign rem       = h_reg - qb_reg;
    assign in_nb     = eff_bytes(key_bytes);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            eval_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            eval_vld_reg <= eval_vld_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        nb_reg       <= nb_next;
        kmask_reg    <= kmask_next;
        key_reg      <= key_next;
        key_raw_reg  <= key_raw_next;
        val_reg      <= val_next;
        byte_idx_reg <= byte_idx_next;
        h_reg        <= h_next;
        q_reg        <= q_next;
        qb_reg       <= qb_next;
        base_reg     <= base_next;
        slot_idx_reg <= slot_idx_next;
        eval_idx_reg <= eval_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_val_reg  <= hit_val_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        nb_next       = nb_reg;
        kmask_next    = kmask_reg;
        key_next      = key_reg;
        key_raw_next  = key_raw_reg;
        val_next      = val_reg;
        byte_idx_next = byte_idx_reg;
        h_next        = h_reg;
        q_next        = q_reg;
        qb_next       = qb_reg;
        base_next     = base_reg;
        slot_idx_next = slot_idx_reg;
        eval_vld_next = 1'b0;
        eval_idx_next = eval_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_val_next  = hit_val_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        count_next    = count_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        res       = '0;

        req           = '0;
        req.wr_key    = key_raw_reg;
        req.wr_val    = val_reg;
        req.rd_addr   = base_reg + SLOT_AW'(slot_idx_reg);

        // multiplier defaults to one hash round
        mul_a = {1'b0, h_reg ^ {24'd0, hash_byte}};
        mul_b = HASH_MULT;

        // compare a slot returned by the memory
        if (eval_vld_reg && rsp.rd_valid)
        begin
            if (!hit_reg && ((rsp.rd_key & kmask_reg) == key_reg))
            begin
                hit_next     = 1'b1;
                hit_idx_next = eval_idx_reg;
                hit_val_next = rsp.rd_val;
            end
        end
        else if (eval_vld_reg && !free_reg)
        begin
            free_next     = 1'b1;
            free_idx_next = eval_idx_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next       = opcode;
                    nb_next       = in_nb;
                    kmask_next    = byte_mask(in_nb);
                    key_next      = key & byte_mask(in_nb);
                    key_raw_next  = key;
                    val_next      = value & VAL_MASK;
                    byte_idx_next = 3'd0;
                    h_next        = FNV_BASIS;
                    state_next    = ST_HASH;
                end
            end

            ST_HASH:
            begin
                h_next        = mul_p[31:0];
                byte_idx_next = byte_idx_reg + 3'd1;
                if ({1'b0, byte_idx_reg} == (nb_reg - 4'd1))
                begin
                    state_next = ST_DIVQ;
                end
            end

            ST_DIVQ:
            begin
                mul_a      = DIV_M;
                mul_b      = h_reg;
                q_next     = 32'(mul_p >> DIV_SH);
                state_next = ST_DIVR;
            end

            ST_DIVR:
            begin
                mul_a      = MUL_AW'(BUCKETS);
                mul_b      = q_reg;
                qb_next    = mul_p[31:0];
                state_next = ST_BASE;
            end

            ST_BASE:
            begin
                base_next     = SLOT_AW'(rem[BKT_W-1:0]) * SLOT_AW'(CHAIN_DEPTH);
                slot_idx_next = '0;
                hit_next      = 1'b0;
                free_next     = 1'b0;
                state_next    = ST_SCAN;
            end

            // one slot read per cycle, compared in the cycle after its read
            ST_SCAN:
            begin
                req.rd_en     = 1'b1;
                eval_vld_next = 1'b1;
                eval_idx_next = slot_idx_reg;
                if (slot_idx_reg == CD_W'(CHAIN_DEPTH - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    slot_idx_next = slot_idx_reg + CD_W'(1);
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end

            ST_COMMIT:
            begin
                if (out_free)
                begin
                    res_valid = 1'b1;
                    res.found = hit_reg;
                    if (op_reg == OP_GET)
                    begin
                        res.value_out = hit_reg ? (hit_val_reg & VAL_MASK) : val_reg;
                    end
                    else if (hit_reg)
                    begin
                        req.wr_val_en = 1'b1;
                        req.wr_addr   = base_reg + SLOT_AW'(hit_idx_reg);
                        res.value_out = val_reg;
                    end
                    else if (free_reg)
                    begin
                        req.wr_val_en = 1'b1;
                        req.wr_key_en = 1'b1;
                        req.wr_addr   = base_reg + SLOT_AW'(free_idx_reg);
                        res.value_out = val_reg;
                        count_next    = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res.bucket_full = 1'b1;
                    end
                    res.entry_count = count_next;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/chained_hash_map_engine_core.sv
// ---------------------------------------------------------------------------
// chained_hash_map_engine_core
// Key-value map with FNV-1a bucket hashing and fixed-depth buckets.
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_ch     sink       valid/ready          opcode, key, value
//  out_ch    source     valid/ready          found, value_out, bucket_full, entry_count
//  apb       slave      psel/penable/pready  key_bytes at byte address 0
//
//  An accepted item steps through the hash, modulo, base, scan, drain and commit
//  states to the result register. The shared multiplier runs one hash round per
//  key byte, then the reciprocal modulo in the DIVQ and DIVR states; the single
//  memory read port walks one slot per cycle.
//  Reset clears the slot valid flags at once; no clearing pass is needed.
//  A stalled result holds in the output register while the next item is
//  accepted; the commit step waits only if that register is still occupied.
// ---------------------------------------------------------------------------
`default_nettype none

module chained_hash_map_engine_core
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    chm_in_if.sink             in_ch,
    chm_out_if.source          out_ch
);
    import chm_pkg::*;

`include "assert_macros.svh"

    logic [KB_W-1:0] key_bytes_reg;
    logic            out_valid_reg;
    result_t         out_res_reg;

    logic       res_valid;
    result_t    res;
    store_req_t req;
    store_rsp_t rsp;
    logic       out_free;
    logic       cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_KEY_BYTES) ? {28'd0, key_bytes_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg <= KEY_BYTES_RST;
        end
        else if (cfg_wr && (paddr[2] == REG_KEY_BYTES))
        begin
            key_bytes_reg <= pwdata[KB_W-1:0];
        end
    end

    chm_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    chm_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .opcode    (in_ch.opcode),
        .key       (in_ch.key),
        .value     (in_ch.value),
        .key_bytes (key_bytes_reg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .req       (req),
        .rsp       (rsp)
    );

    // output register
    assign out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.found       = out_res_reg.found;
    assign out_ch.value_out   = out_res_reg.value_out;
    assign out_ch.bucket_full = out_res_reg.bucket_full;
    assign out_ch.entry_count = out_res_reg.entry_count;

    // checks
    `CHM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready,
        !in_ch.ready, "engine still ready after accepting an item")
    `CHM_ASSERT_IMP(a_no_result_overwrite, clk, rst_n, res_valid,
        !out_valid_reg || out_ch.ready, "result written over a waiting result")
    `CHM_ASSERT_IMP(a_dropped_set_clean, clk, rst_n, out_ch.valid && out_ch.bucket_full,
        !out_ch.found && (out_ch.value_out == '0), "dropped set reports a value or a hit")

endmodule

`default_nettype wire
